### rtl/core/hmap_pkg.sv
// Shared constants for the chunked heightmap bilinear sampler.
// No dependencies. Every other file in rtl/core but hmap_bank uses it.
package hmap_pkg;

   // Default values of the top level parameters
   localparam int CHUNKS_PER_SIDE   = 4;
   localparam int TILES_PER_CHUNK_X = 16;
   localparam int TILES_PER_CHUNK_Y = 16;
   localparam int TILE_SCALE        = 2;
   localparam int HEIGHT_BITS       = 16;

   // Fixed field widths
   localparam int POS_W       = 24;  // Q15.8 position
   localparam int HGT_W       = 16;  // Q7.8 height
   localparam int FRAC_W      = 8;
   localparam int GRID_W      = POS_W - FRAC_W;
   localparam int REL_W       = GRID_W + 2;
   localparam int WIN_W       = 10;
   localparam int CHUNK_SEL_W = 2;
   localparam int VTX_W       = 9;
   localparam int CSR_IDX_W   = 2;

   // Result queue depth; covers pipeline latency for full rate
   localparam int RSP_FIFO_DEPTH = 16;

   // Item function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_Y = 2'd1;

endpackage

### rtl/core/hmap_if.sv
// Channel interfaces: request, response and register write channels.
// Depends on hmap_pkg.
interface hmap_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic [hmap_pkg::CHUNK_SEL_W-1:0]     chunk_col;
   logic [hmap_pkg::CHUNK_SEL_W-1:0]     chunk_row;
   logic [hmap_pkg::VTX_W-1:0]           vertex_index;
   logic signed [hmap_pkg::HGT_W-1:0]    height_in;
   logic signed [hmap_pkg::POS_W-1:0]    pos_x;
   logic signed [hmap_pkg::POS_W-1:0]    pos_y;
   modport source (output valid, func, chunk_col, chunk_row, vertex_index, height_in,
                   pos_x, pos_y, input ready);
   modport sink (input valid, func, chunk_col, chunk_row, vertex_index, height_in,
                 pos_x, pos_y, output ready);
endinterface

interface hmap_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [hmap_pkg::HGT_W-1:0] height_out;
   modport source (output valid, height_out, input ready);
   modport sink (input valid, height_out, output ready);
endinterface

interface hmap_csr_if;
   logic                               valid;
   logic                               ready;
   logic [hmap_pkg::CSR_IDX_W-1:0]     index;
   logic [hmap_pkg::WIN_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/hmap_axis.sv
// One axis of position split: floor(pos / TILE_SCALE) as grid corner and fraction.
// Two register stages. Depends on hmap_pkg.
module hmap_axis #(
   parameter int TILE_SCALE = hmap_pkg::TILE_SCALE
) (
   input  logic                               clock,
   input  logic signed [hmap_pkg::POS_W-1:0]  pos,
   output logic signed [hmap_pkg::GRID_W-1:0] grid_ff,
   output logic [hmap_pkg::FRAC_W-1:0]        frac_ff
);
   localparam int UW = hmap_pkg::POS_W + $clog2(TILE_SCALE) + 1;
   localparam int PW = UW + 33;
   localparam logic [UW-1:0] OFFSET = UW'(TILE_SCALE) << (hmap_pkg::POS_W - 1);
   localparam logic [UW-1:0] HALF   = UW'(1) << (hmap_pkg::POS_W - 1);
   localparam logic [32:0]   RECIP  = 33'((64'd1 << 32) / TILE_SCALE);

   logic [UW-1:0] u_in, u_ff, q, r, qc, fl;
   logic [PW-1:0] prod_in, prod_ff;
   logic signed [hmap_pkg::GRID_W-1:0] grid_in;
   logic [hmap_pkg::FRAC_W-1:0]        frac_in;

   // biased to non-negative so the reciprocal multiply floors correctly
   always_comb begin
      u_in    = UW'(pos) + OFFSET;
      prod_in = PW'(u_in) * PW'(RECIP);
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      prod_ff <= prod_in;
   end

   // quotient estimate is low by at most one
   always_comb begin
      q       = UW'(prod_ff[PW-1:32]);
      r       = u_ff - q * UW'(TILE_SCALE);
      qc      = q + UW'(r >= UW'(TILE_SCALE));
      fl      = qc - HALF;
      grid_in = fl[hmap_pkg::POS_W-1:hmap_pkg::FRAC_W];
      frac_in = fl[hmap_pkg::FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      grid_ff <= grid_in;
      frac_ff <= frac_in;
   end
endmodule

### rtl/core/hmap_corner.sv
// Window-relative grid coordinate to chunk and local index, one register stage.
// Depends on hmap_pkg.
module hmap_corner #(
   parameter int TILES           = hmap_pkg::TILES_PER_CHUNK_X,
   parameter int CHUNKS_PER_SIDE = hmap_pkg::CHUNKS_PER_SIDE,
   localparam int CW = (CHUNKS_PER_SIDE > 1) ? $clog2(CHUNKS_PER_SIDE) : 1,
   localparam int LW = $clog2(TILES)
) (
   input  logic                              clock,
   input  logic signed [hmap_pkg::REL_W-1:0] rel,
   output logic                              ok_ff,
   output logic [CW-1:0]                     chunk_ff,
   output logic [LW-1:0]                     loc_ff
);
   localparam int RW   = hmap_pkg::REL_W;
   localparam int SPAN = CHUNKS_PER_SIDE * TILES;

   logic [RW-1:0] rel_u;
   logic          ok_in;
   logic [CW-1:0] chunk_in;
   logic [LW-1:0] loc_in;

   always_comb begin
      rel_u    = rel;
      ok_in    = !rel_u[RW-1] && (rel_u < RW'(SPAN));
      chunk_in = '0;
      for (int k = 1; k < CHUNKS_PER_SIDE; k++) begin
         if (rel_u >= RW'(k * TILES)) chunk_in = chunk_in + 1'b1;
      end
      loc_in = LW'(rel_u - RW'(chunk_in) * RW'(TILES));
   end

   always_ff @(posedge clock) begin
      ok_ff    <= ok_in;
      chunk_ff <= chunk_in;
      loc_ff   <= loc_in;
   end
endmodule

### rtl/core/hmap_bank.sv
// Height store copy: one write port, one registered read port.
// No dependencies.
module hmap_bank #(
   parameter int DEPTH = 4624,
   parameter int DW    = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data_ff
);
   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

### rtl/core/hmap_interp.sv
// Bilinear blend of four corner heights, two register stages, then round and clamp.
// Depends on hmap_pkg.
module hmap_interp (
   input  logic                              clock,
   input  logic signed [hmap_pkg::HGT_W-1:0] h00,
   input  logic signed [hmap_pkg::HGT_W-1:0] h01,
   input  logic signed [hmap_pkg::HGT_W-1:0] h10,
   input  logic signed [hmap_pkg::HGT_W-1:0] h11,
   input  logic [hmap_pkg::FRAC_W-1:0]       fx,
   input  logic [hmap_pkg::FRAC_W-1:0]       fy,
   output logic signed [hmap_pkg::HGT_W-1:0] res
);
   logic signed [16:0] d0, d1;
   logic signed [25:0] pa, pb;
   logic signed [26:0] a_in, b_in, a_ff, b_ff;
   logic signed [27:0] dab;
   logic signed [35:0] pv;
   logic signed [35:0] v_in, v_ff, t;
   logic signed [19:0] q;
   logic [hmap_pkg::FRAC_W-1:0] fy_ff;

   // products sized by their targets: 17x9 and 28x9 bits
   always_comb begin
      d0   = 17'(h10) - 17'(h00);
      d1   = 17'(h11) - 17'(h01);
      pa   = d0 * $signed({1'b0, fx});
      pb   = d1 * $signed({1'b0, fx});
      a_in = (27'(h00) <<< 8) + 27'(pa);
      b_in = (27'(h01) <<< 8) + 27'(pb);
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      fy_ff <= fy;
   end

   always_comb begin
      dab  = 28'(b_ff) - 28'(a_ff);
      pv   = dab * $signed({1'b0, fy_ff});
      v_in = (36'(a_ff) <<< 8) + pv;
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   // round half up, then clamp
   always_comb begin
      t = v_ff + 36'sd32768;
      q = t[35:16];
      if (q > 20'sd32767) begin
         res = 16'sh7fff;
      end else if (q < -20'sd32768) begin
         res = -16'sh8000;
      end else begin
         res = q[15:0];
      end
   end
endmodule

### rtl/core/hmap_rsp_fifo.sv
// Result queue between the sample pipeline and the response channel.
// Depends on hmap_pkg.
module hmap_rsp_fifo #(
   parameter int DEPTH = hmap_pkg::RSP_FIFO_DEPTH,
   localparam int AW   = $clog2(DEPTH),
   localparam int CNTW = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic signed [hmap_pkg::HGT_W-1:0] din,
   input  logic                              pop,
   output logic                              nonempty,
   output logic signed [hmap_pkg::HGT_W-1:0] dout,
   output logic [CNTW-1:0]                   count_ff
);
   logic signed [hmap_pkg::HGT_W-1:0] mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNTW-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= din;
   end

   assign nonempty = (count_ff != '0);
   assign dout     = mem[rd_ptr_ff];
endmodule

### rtl/core/chunked_heightmap_bilinear_sampler_core.sv
// Top level of the chunked heightmap bilinear sampler.
// Depends on hmap_pkg, hmap_if, hmap_axis, hmap_corner, hmap_bank, hmap_interp, hmap_rsp_fifo.
//
//  channel | dir | transaction
//  --------+-----+-------------------------------------------------------
//  req     | in  | height write (func=0) or sample request (func=1)
//  rsp     | out | one interpolated height per sample, in request order
//  csr     | in  | window origin write, index 0 = chunk x, 1 = chunk y
//
// One transaction per cycle on req while credits remain. A sample reaches the
// result queue via the input registers, reciprocal multiply, window offset, corner
// decode, store address, registered store read and two blend multiplies.
// Reset is synchronous and clears control state only; the store has no reset.
// The pipeline never stalls: req.ready drops only when result-queue credits run
// out, so a held rsp throttles intake without losing or repeating anything.
module chunked_heightmap_bilinear_sampler_core #(
   parameter int CHUNKS_PER_SIDE   = hmap_pkg::CHUNKS_PER_SIDE,
   parameter int TILES_PER_CHUNK_X = hmap_pkg::TILES_PER_CHUNK_X,
   parameter int TILES_PER_CHUNK_Y = hmap_pkg::TILES_PER_CHUNK_Y,
   parameter int TILE_SCALE        = hmap_pkg::TILE_SCALE,
   parameter int HEIGHT_BITS       = hmap_pkg::HEIGHT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   hmap_req_if.sink    req,
   hmap_rsp_if.source  rsp,
   hmap_csr_if.sink    csr
);
   localparam int VPR   = TILES_PER_CHUNK_X + 1;
   localparam int VPC   = (TILES_PER_CHUNK_X + 1) * (TILES_PER_CHUNK_Y + 1);
   localparam int DEPTH = CHUNKS_PER_SIDE * CHUNKS_PER_SIDE * VPC;
   localparam int AW    = $clog2(DEPTH);
   localparam int KEEP  = (HEIGHT_BITS < hmap_pkg::HGT_W) ? HEIGHT_BITS : hmap_pkg::HGT_W;
   localparam int CW    = (CHUNKS_PER_SIDE > 1) ? $clog2(CHUNKS_PER_SIDE) : 1;
   localparam int LXW   = $clog2(TILES_PER_CHUNK_X);
   localparam int LYW   = $clog2(TILES_PER_CHUNK_Y);
   localparam int FD    = hmap_pkg::RSP_FIFO_DEPTH;
   localparam int CRW   = $clog2(FD + 1);
   localparam int RW    = hmap_pkg::REL_W;
   localparam int HW    = hmap_pkg::HGT_W;
   localparam int FW    = hmap_pkg::FRAC_W;

   // ---------------- window registers ----------------
   logic [hmap_pkg::WIN_W-1:0] win_x_ff, win_y_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_ff <= '0;
         win_y_ff <= '0;
      end else if (csr.valid) begin
         if (csr.index == hmap_pkg::REG_WINDOW_X) win_x_ff <= csr.data;
         if (csr.index == hmap_pkg::REG_WINDOW_Y) win_y_ff <= csr.data;
      end
   end

   // ---------------- intake and credits ----------------
   // a credit is a reserved result-queue slot; only samples take one
   logic           accept, smp_accept, fifo_pop, fifo_push, fifo_nonempty;
   logic [CRW-1:0] credit_ff, credit_in;
   logic [CRW-1:0] fifo_count;
   logic signed [HW-1:0] res, fifo_dout;

   assign req.ready  = (credit_ff != '0);
   assign accept     = req.valid && req.ready;
   assign smp_accept = accept && (req.func == hmap_pkg::FUNC_SAMPLE);
   assign fifo_pop   = rsp.valid && rsp.ready;

   always_comb begin
      credit_in = credit_ff - CRW'(smp_accept) + CRW'(fifo_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) credit_ff <= CRW'(FD);
      else       credit_ff <= credit_in;
   end

   // ---------------- stage 1: input registers ----------------
   logic sv_ff [1:9];     // sample valid per stage
   logic wv1_ff;
   logic [hmap_pkg::CHUNK_SEL_W-1:0] col1_ff, row1_ff;
   logic [hmap_pkg::VTX_W-1:0]       vi1_ff;
   logic [KEEP-1:0]                  hin1_ff;
   logic signed [hmap_pkg::POS_W-1:0] px1_ff, py1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 9; i++) sv_ff[i] <= 1'b0;
         wv1_ff <= 1'b0;
      end else begin
         sv_ff[1] <= smp_accept;
         for (int i = 2; i <= 9; i++) sv_ff[i] <= sv_ff[i-1];
         wv1_ff <= accept && (req.func == hmap_pkg::FUNC_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      col1_ff <= req.chunk_col;
      row1_ff <= req.chunk_row;
      vi1_ff  <= req.vertex_index;
      hin1_ff <= req.height_in[KEEP-1:0];
      px1_ff  <= req.pos_x;
      py1_ff  <= req.pos_y;
   end

   // ---------------- write path: delayed to the store stage ----------------
   // writes land on the same edge as sample reads, keeping request order
   logic            wen_ff   [2:6];
   logic [AW-1:0]   waddr_ff [2:6];
   logic [KEEP-1:0] wdata_ff [2:6];
   logic            wok;
   logic [AW-1:0]   waddr_in;

   always_comb begin
      wok = (int'(col1_ff) < CHUNKS_PER_SIDE) && (int'(row1_ff) < CHUNKS_PER_SIDE)
            && (int'(vi1_ff) < VPC);
      waddr_in = AW'((AW'(col1_ff) * AW'(CHUNKS_PER_SIDE) + AW'(row1_ff)) * AW'(VPC)
                     + AW'(vi1_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 2; i <= 6; i++) wen_ff[i] <= 1'b0;
      end else begin
         wen_ff[2] <= wv1_ff && wok;
         for (int i = 3; i <= 6; i++) wen_ff[i] <= wen_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff[2] <= waddr_in;
      wdata_ff[2] <= hin1_ff;
      for (int i = 3; i <= 6; i++) begin
         waddr_ff[i] <= waddr_ff[i-1];
         wdata_ff[i] <= wdata_ff[i-1];
      end
   end

   // ---------------- stages 2-3: grid corner and fraction ----------------
   logic signed [hmap_pkg::GRID_W-1:0] gx3, gy3;
   logic [FW-1:0] fx3, fy3;

   hmap_axis #(.TILE_SCALE(TILE_SCALE)) u_axis_x (
      .clock(clock), .pos(px1_ff), .grid_ff(gx3), .frac_ff(fx3));
   hmap_axis #(.TILE_SCALE(TILE_SCALE)) u_axis_y (
      .clock(clock), .pos(py1_ff), .grid_ff(gy3), .frac_ff(fy3));

   // fractions ride along to the blend stage
   logic [FW-1:0] fx_ff [4:7];
   logic [FW-1:0] fy_ff [4:7];

   always_ff @(posedge clock) begin
      fx_ff[4] <= fx3;
      fy_ff[4] <= fy3;
      for (int i = 5; i <= 7; i++) begin
         fx_ff[i] <= fx_ff[i-1];
         fy_ff[i] <= fy_ff[i-1];
      end
   end

   // ---------------- stage 4: window-relative coordinates ----------------
   logic [RW-1:0]        wofs_x, wofs_y;
   logic signed [RW-1:0] relx_ff, rely_ff, relx_in, rely_in;

   always_comb begin
      wofs_x  = RW'(win_x_ff) * RW'(TILES_PER_CHUNK_X);
      wofs_y  = RW'(win_y_ff) * RW'(TILES_PER_CHUNK_Y);
      relx_in = RW'(gx3) - wofs_x;
      rely_in = RW'(gy3) - wofs_y;
   end

   always_ff @(posedge clock) begin
      relx_ff <= relx_in;
      rely_ff <= rely_in;
   end

   // ---------------- stage 5: chunk and local index per coordinate ----------------
   logic           okx0, okx1, oky0, oky1;
   logic [CW-1:0]  cx0, cx1, cy0, cy1;
   logic [LXW-1:0] lx0, lx1;
   logic [LYW-1:0] ly0, ly1;

   hmap_corner #(.TILES(TILES_PER_CHUNK_X), .CHUNKS_PER_SIDE(CHUNKS_PER_SIDE)) u_cx0 (
      .clock(clock), .rel(relx_ff), .ok_ff(okx0), .chunk_ff(cx0), .loc_ff(lx0));
   hmap_corner #(.TILES(TILES_PER_CHUNK_X), .CHUNKS_PER_SIDE(CHUNKS_PER_SIDE)) u_cx1 (
      .clock(clock), .rel(relx_ff + RW'(1)), .ok_ff(okx1), .chunk_ff(cx1), .loc_ff(lx1));
   hmap_corner #(.TILES(TILES_PER_CHUNK_Y), .CHUNKS_PER_SIDE(CHUNKS_PER_SIDE)) u_cy0 (
      .clock(clock), .rel(rely_ff), .ok_ff(oky0), .chunk_ff(cy0), .loc_ff(ly0));
   hmap_corner #(.TILES(TILES_PER_CHUNK_Y), .CHUNKS_PER_SIDE(CHUNKS_PER_SIDE)) u_cy1 (
      .clock(clock), .rel(rely_ff + RW'(1)), .ok_ff(oky1), .chunk_ff(cy1), .loc_ff(ly1));

   // ---------------- stage 6: store addresses ----------------
   // corner order: 0 = h00, 1 = h01 (y+1), 2 = h10 (x+1), 3 = h11
   logic          rok_in [4];
   logic [AW-1:0] radr_in [4];
   logic          rok_ff [4];
   logic [AW-1:0] radr_ff [4];
   logic          ok7_ff [4];

   function automatic logic [AW-1:0] vtx_addr(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                              input logic [LXW-1:0] lx,
                                              input logic [LYW-1:0] ly);
      return AW'((AW'(cx) * AW'(CHUNKS_PER_SIDE) + AW'(cy)) * AW'(VPC)
                 + AW'(ly) * AW'(VPR) + AW'(lx));
   endfunction

   always_comb begin
      rok_in[0]  = okx0 && oky0;
      rok_in[1]  = okx0 && oky1;
      rok_in[2]  = okx1 && oky0;
      rok_in[3]  = okx1 && oky1;
      radr_in[0] = vtx_addr(cx0, cy0, lx0, ly0);
      radr_in[1] = vtx_addr(cx0, cy1, lx0, ly1);
      radr_in[2] = vtx_addr(cx1, cy0, lx1, ly0);
      radr_in[3] = vtx_addr(cx1, cy1, lx1, ly1);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         rok_ff[i]  <= rok_in[i];
         radr_ff[i] <= radr_in[i];
         ok7_ff[i]  <= rok_ff[i];
      end
   end

   // ---------------- stage 7: four store copies, one per corner ----------------
   logic [KEEP-1:0]      rdata [4];
   logic signed [HW-1:0] hc [4];

   for (genvar g = 0; g < 4; g++) begin : g_bank
      hmap_bank #(.DEPTH(DEPTH), .DW(KEEP)) u_bank (
         .clock     (clock),
         .wr_en     (wen_ff[6]),
         .wr_addr   (waddr_ff[6]),
         .wr_data   (wdata_ff[6]),
         .rd_addr   (radr_ff[g]),
         .rd_data_ff(rdata[g]));
      // corners outside the window read zero
      assign hc[g] = ok7_ff[g] ? HW'($signed(rdata[g])) : '0;
   end

   // ---------------- stages 8-9: blend, then result queue ----------------
   hmap_interp u_interp (
      .clock(clock), .h00(hc[0]), .h01(hc[1]), .h10(hc[2]), .h11(hc[3]),
      .fx(fx_ff[7]), .fy(fy_ff[7]), .res(res));

   assign fifo_push = sv_ff[9];

   hmap_rsp_fifo #(.DEPTH(FD)) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .din     (res),
      .pop     (fifo_pop),
      .nonempty(fifo_nonempty),
      .dout    (fifo_dout),
      .count_ff(fifo_count));

   assign rsp.valid      = fifo_nonempty;
   assign rsp.height_out = fifo_dout;

   // ---------------- assertions ----------------
   // credits guarantee the queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (fifo_push && !fifo_pop) |-> (fifo_count != CRW'(FD)))
      else $error("result queue overflow");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRW'(FD))
      else $error("credit count above queue depth");

   // outstanding results never exceed reserved slots
   a_queue_vs_credit: assert property (@(posedge clock) disable iff (reset)
      (32'(fifo_count) + 32'(credit_ff)) <= FD)
      else $error("queue and credits out of step");

   a_sample_enters: assert property (@(posedge clock) disable iff (reset)
      smp_accept |=> sv_ff[1])
      else $error("accepted sample lost at intake");

endmodule

### verif/tb_chunked_heightmap_bilinear_sampler_core.sv
// Self-checking testbench for chunked_heightmap_bilinear_sampler_core.
// Depends on hmap_pkg, hmap_if and the core; drives req and csr, checks rsp against
// a built-in model of the height store, the window and the bilinear blend.
module tb_chunked_heightmap_bilinear_sampler_core;
   timeunit 1ns;
   timeprecision 1ps;
   import hmap_pkg::*;

   localparam int VTX_ROW    = TILES_PER_CHUNK_X + 1;
   localparam int VTX_CHUNK  = VTX_ROW * (TILES_PER_CHUNK_Y + 1);
   localparam int STORE_SIZE = CHUNKS_PER_SIDE * CHUNKS_PER_SIDE * VTX_CHUNK;
   localparam int CELL_RAW   = 256 * TILE_SCALE;   // raw position units per grid cell
   localparam int SETTLE     = 16;                 // extra cycles waited after the pending heights drain
   localparam int LIMIT      = 400000;
   localparam int N_RANDOM   = 440;

   typedef struct {
      logic                      func;
      logic [CHUNK_SEL_W-1:0]    col;
      logic [CHUNK_SEL_W-1:0]    row;
      logic [VTX_W-1:0]          vtx;
      logic signed [HGT_W-1:0]   hgt;
      logic signed [POS_W-1:0]   px;
      logic signed [POS_W-1:0]   py;
      bit                        typed;   // expected height given in the table
      logic signed [HGT_W-1:0]   want;
   } hmap_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hmap_req_if req_if();
   hmap_rsp_if rsp_if();
   hmap_csr_if csr_if();

   chunked_heightmap_bilinear_sampler_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   always #5 clock = ~clock;

   // Model state: heights, window origin, pending interpolated heights
   logic signed [HGT_W-1:0] heights_mdl [STORE_SIZE];
   logic [WIN_W-1:0]        win_x_mdl;
   logic [WIN_W-1:0]        win_y_mdl;
   logic signed [HGT_W-1:0] height_due_q [$];

   int  n_bad     = 0;
   int  n_cycles  = 0;
   bit  tx_calm   = 1'b0;   // sender never idles while set
   bit  rx_calm   = 1'b1;   // receiver never stalls while set

   // Local vertex columns and rows loaded in every chunk: first two and last read
   int  load_x [3] = '{0, 1, TILES_PER_CHUNK_X - 1};
   int  load_y [3] = '{0, 1, TILES_PER_CHUNK_Y - 1};

   // Height of one grid corner; corners left of, above or past the window read zero
   function automatic longint corner_height(longint gx, longint gy);
      longint rx, ry, cx, cy;
      rx = gx - longint'(win_x_mdl) * TILES_PER_CHUNK_X;
      ry = gy - longint'(win_y_mdl) * TILES_PER_CHUNK_Y;
      if (rx < 0 || ry < 0) return 0;
      cx = rx / TILES_PER_CHUNK_X;
      cy = ry / TILES_PER_CHUNK_Y;
      if (cx >= CHUNKS_PER_SIDE || cy >= CHUNKS_PER_SIDE) return 0;
      return longint'(heights_mdl[(cx * CHUNKS_PER_SIDE + cy) * VTX_CHUNK
                      + (ry % TILES_PER_CHUNK_Y) * VTX_ROW + (rx % TILES_PER_CHUNK_X)]);
   endfunction

   function automatic logic signed [HGT_W-1:0] blend_height(logic signed [POS_W-1:0] px,
                                                            logic signed [POS_W-1:0] py);
      longint x, y, gx, gy, fx, fy, h00, h01, h10, h11, a, b, v, res;
      x   = longint'(px);
      y   = longint'(py);
      gx  = x >>> $clog2(CELL_RAW);            // floor division by the cell size
      gy  = y >>> $clog2(CELL_RAW);
      fx  = (x - gx * CELL_RAW) / TILE_SCALE;
      fy  = (y - gy * CELL_RAW) / TILE_SCALE;
      h00 = corner_height(gx, gy);
      h01 = corner_height(gx, gy + 1);
      h10 = corner_height(gx + 1, gy);
      h11 = corner_height(gx + 1, gy + 1);
      a   = h00 * 256 + (h10 - h00) * fx;
      b   = h01 * 256 + (h11 - h01) * fx;
      v   = a * 256 + (b - a) * fy;
      res = (v + 32768) >>> 16;                // round half up
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res[HGT_W-1:0];
   endfunction

   // Update model at acceptance; samples queue their expected height
   function automatic void accept_op(hmap_op_type op);
      if (op.func == FUNC_WRITE) begin
         if (op.vtx < VTX_CHUNK)
            heights_mdl[(op.col * CHUNKS_PER_SIDE + op.row) * VTX_CHUNK + op.vtx] = op.hgt;
      end else if (op.typed) begin
         height_due_q.push_back(op.want);
      end else begin
         height_due_q.push_back(blend_height(op.px, op.py));
      end
   endfunction

   task automatic send_op(hmap_op_type op);
      while (!tx_calm && $urandom_range(99) < 17) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.func         <= op.func;
      req_if.chunk_col    <= op.col;
      req_if.chunk_row    <= op.row;
      req_if.vertex_index <= op.vtx;
      req_if.height_in    <= op.hgt;
      req_if.pos_x        <= op.px;
      req_if.pos_y        <= op.py;
      do @(posedge clock); while (!req_if.ready);
      accept_op(op);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (height_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Window writes go in only with the pipe empty
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == REG_WINDOW_X) win_x_mdl = val;
      else if (idx == REG_WINDOW_Y) win_y_mdl = val;
      @(posedge clock);
   endtask

   function automatic hmap_op_type write_op(int col, int row, int vtx, int hgt);
      hmap_op_type op;
      op.func = FUNC_WRITE;
      op.col = CHUNK_SEL_W'(col); op.row = CHUNK_SEL_W'(row);
      op.vtx = VTX_W'(vtx); op.hgt = HGT_W'(hgt);
      op.px = POS_W'($urandom); op.py = POS_W'($urandom);
      op.typed = 1'b0; op.want = '0;
      return op;
   endfunction

   function automatic hmap_op_type sample_op(int px, int py, bit typed, int want);
      hmap_op_type op;
      op.func = FUNC_SAMPLE;
      op.col = CHUNK_SEL_W'($urandom); op.row = CHUNK_SEL_W'($urandom);
      op.vtx = VTX_W'($urandom); op.hgt = HGT_W'($urandom);
      op.px = POS_W'(px); op.py = POS_W'(py);
      op.typed = typed; op.want = HGT_W'(want);
      return op;
   endfunction

   // Position in a grid cell whose corners are loaded or lie outside the window:
   // first or last cell of a window chunk, or one or two cells before the window
   function automatic logic signed [POS_W-1:0] near_window(logic [WIN_W-1:0] win, int tiles);
      longint g, p;
      int     k;
      k = int'($urandom_range(CHUNKS_PER_SIDE - 1));
      case ($urandom_range(3))
         0:       g = longint'(k) * tiles;
         1:       g = longint'(k) * tiles + tiles - 1;
         2:       g = -1;
         default: g = -2;
      endcase
      g = g + longint'(win) * tiles;
      p = g * CELL_RAW + longint'($urandom_range(CELL_RAW - 1));
      // past the position range: a cell left of any window
      if (p > 8388607 || p < -8388608) p = -2 * CELL_RAW + longint'($urandom_range(CELL_RAW - 1));
      return p[POS_W-1:0];
   endfunction

   // Response check: compare against the oldest pending height
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (height_due_q.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("[%0t] unexpected height_out %0d", $realtime, rsp_if.height_out);
            end else begin
               if (rsp_if.height_out !== height_due_q[0]) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("[%0t] height_out mismatch: expected %0d, got %0d",
                              $realtime, height_due_q[0], rsp_if.height_out);
               end
               void'(height_due_q.pop_front());
            end
         end
         rsp_if.ready <= rx_calm || ($urandom_range(99) >= 17);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > LIMIT) begin
         $display("** chunked_heightmap_bilinear_sampler_core: FAILED **");
         $finish;
      end
   end

   // Directed rows. Chunk (0,0) corners at grid (0..1, 0..1) are written before
   // any sample touches them; everything else sampled here lies outside the window.
   hmap_op_type directed [] = '{
      sample_op(-CELL_RAW - 1, -CELL_RAW - 1, 1'b1, 0),    // left of and above window
      sample_op(-8388608, -8388608, 1'b1, 0),              // most negative position
      sample_op(8388607, 8388607, 1'b1, 0),                // chunk index past window
      sample_op(8388607, -8388608, 1'b1, 0),
      write_op(0, 0, 0, 32767),
      write_op(0, 0, 1, 32767),
      write_op(0, 0, VTX_ROW, 32767),
      write_op(0, 0, VTX_ROW + 1, 32767),
      write_op(3, 3, VTX_CHUNK - 1, -32768),               // last entry, never read
      write_op(1, 2, VTX_CHUNK, 1234),                     // index past grid: dropped
      write_op(2, 1, 511, -1),                             // all index bits set: dropped
      sample_op(0, 0, 1'b1, 32767),                        // zero fraction
      sample_op(CELL_RAW - 1, CELL_RAW - 1, 1'b1, 32767),  // largest fraction
      sample_op(CELL_RAW / 2, 1, 1'b1, 32767),
      sample_op(-1, 0, 1'b0, 0),                           // blend against a zero corner
      sample_op(0, -CELL_RAW, 1'b0, 0),
      write_op(0, 0, 0, -32768),
      sample_op(CELL_RAW / 2, CELL_RAW / 2, 1'b0, 0),
      sample_op(1, 1, 1'b0, 0)
   };

   logic [WIN_W-1:0] win_x_plan [4] = '{10'd0, 10'd1023, 10'd5, 10'd0};
   logic [WIN_W-1:0] win_y_plan [4] = '{10'd0, 10'd1023, 10'd3, 10'd0};

   initial begin
      hmap_op_type op;
      int          pick;
      req_if.valid = 1'b0;
      req_if.func = FUNC_WRITE;
      req_if.chunk_col = '0;
      req_if.chunk_row = '0;
      req_if.vertex_index = '0;
      req_if.height_in = '0;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_WINDOW_X;
      csr_if.data = '0;
      foreach (heights_mdl[i]) heights_mdl[i] = '0;
      win_x_mdl = '0;
      win_y_mdl = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_op(directed[i]);

      // Load every vertex that later samples can reach
      tx_calm = 1'b1;
      for (int c = 0; c < CHUNKS_PER_SIDE; c++)
         for (int r = 0; r < CHUNKS_PER_SIDE; r++)
            for (int iy = 0; iy < 3; iy++)
               for (int ix = 0; ix < 3; ix++)
                  send_op(write_op(c, r, load_y[iy] * VTX_ROW + load_x[ix],
                                   int'($urandom_range(16'hFFFF))));
      tx_calm = 1'b0;
      rx_calm = 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         if (ph == 3) begin
            win_x_plan[ph] = WIN_W'($urandom);
            win_y_plan[ph] = WIN_W'($urandom);
            write_reg(2'd2, WIN_W'($urandom));        // unmapped indexes: no effect
            write_reg(2'd3, WIN_W'($urandom));
         end
         write_reg(REG_WINDOW_X, win_x_plan[ph]);
         write_reg(REG_WINDOW_Y, win_y_plan[ph]);
         tx_calm = (ph == 1);
         rx_calm = (ph == 2);
         for (int n = 0; n < N_RANDOM / 4; n++) begin
            if (ph == 0 && n == 60) begin
               // hold off until every pending height has come back
               req_if.valid <= 1'b0;
               @(posedge clock);
               while (height_due_q.size() != 0) @(posedge clock);
            end
            pick = $urandom_range(99);
            if (pick < 65)
               op = sample_op(int'(near_window(win_x_mdl, TILES_PER_CHUNK_X)),
                              int'(near_window(win_y_mdl, TILES_PER_CHUNK_Y)), 1'b0, 0);
            else if (pick < 75)
               // any x, with y in a row above every window
               op = sample_op(int'($urandom), -2 * CELL_RAW - 1, 1'b0, 0);
            else if (pick < 95)
               op = write_op($urandom, $urandom, $urandom_range(VTX_CHUNK - 1), $urandom);
            else
               op = write_op($urandom, $urandom, $urandom_range(511, VTX_CHUNK), $urandom);
            send_op(op);
         end
      end

      rx_calm = 1'b0;
      drain();
      if (n_bad == 0 && height_due_q.size() == 0) begin
         $display("** chunked_heightmap_bilinear_sampler_core: PASSED **");
      end else begin
         $display("** chunked_heightmap_bilinear_sampler_core: FAILED **");
      end
      $finish;
   end

endmodule
